### rtl/core/clnb_pkg.sv
// Shared types and constants for the character LCD nibble bus sequencer.
package clnb_pkg;

    localparam int STEP_W  = 5;
    localparam int PHASE_W = 3;
    localparam int OP_W    = 3;
    localparam int PADDR_W = 5;

    // operations
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_CMD    = 3'd1;
    localparam logic [OP_W-1:0] OP_DATA   = 3'd2;
    localparam logic [OP_W-1:0] OP_INIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CURSOR = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_POWER  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_EN     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_SETTLE = 3'd3;
    localparam logic [PHASE_W-1:0] PH_GAP    = 3'd4;
    localparam logic [PHASE_W-1:0] PH_EXTRA  = 3'd5;

    // sequence steps
    localparam logic [STEP_W-1:0] STEP_IDLE       = 5'd0;
    localparam logic [STEP_W-1:0] STEP_POWER      = 5'd1;
    localparam logic [STEP_W-1:0] STEP_WAKE_FIRST = 5'd2;
    localparam logic [STEP_W-1:0] STEP_BUS4       = 5'd5;
    localparam logic [STEP_W-1:0] STEP_CMD_FIRST  = 5'd6;
    localparam logic [STEP_W-1:0] STEP_CMD_LAST   = 5'd9;
    localparam logic [STEP_W-1:0] STEP_SINGLE     = 5'd10;

    // longest chain of zero-length waits resolved within one request
    localparam int ZERO_RUN_MAX = 4;

    localparam logic [3:0] WAKE_NIBBLE = 4'h3;
    localparam logic [3:0] BUS4_NIBBLE = 4'h2;
    localparam logic [7:0] CURSOR_CMD  = 8'h80;
    localparam logic [7:0] CLEAR_CMD   = 8'h01;
    localparam logic [6:0] LINE0_BASE  = 7'h00;
    localparam logic [6:0] LINE1_BASE  = 7'h40;

    // register indexes
    localparam logic [2:0] REG_PULSE_HIGH = 3'd0;
    localparam logic [2:0] REG_SETTLE     = 3'd1;
    localparam logic [2:0] REG_POST_BYTE  = 3'd2;
    localparam logic [2:0] REG_POWER_UP   = 3'd3;
    localparam logic [2:0] REG_FIRST_WAKE = 3'd4;
    localparam logic [2:0] REG_WAKE       = 3'd5;

    localparam logic [7:0]  RST_PULSE_HIGH = 8'd1;
    localparam logic [15:0] RST_SETTLE     = 16'd100;
    localparam logic [15:0] RST_POST_BYTE  = 16'd2000;
    localparam logic [15:0] RST_POWER_UP   = 16'd40000;
    localparam logic [15:0] RST_FIRST_WAKE = 16'd5000;
    localparam logic [15:0] RST_WAKE       = 16'd150;

    typedef struct packed {
        logic [7:0]  pulse_high_us;
        logic [15:0] settle_us;
        logic [15:0] post_byte_us;
        logic [15:0] power_up_us;
        logic [15:0] first_wake_us;
        logic [15:0] wake_us;
    } t_cfg;

    typedef struct packed {
        logic       rs_level;
        logic       en_level;
        logic [3:0] bus_nibble;
        logic       busy_res;
        logic       accepted;
    } t_result;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h28;
            2'd1:    c = 8'h0C;
            2'd2:    c = 8'h06;
            default: c = 8'h01;
        endcase
        return c;
    endfunction

endpackage

### rtl/core/clnb_cfg_regs.sv
// APB timing registers for the LCD nibble bus sequencer.
module clnb_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clnb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output clnb_pkg::t_cfg                o_cfg
);

    clnb_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [2:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_high_us <= clnb_pkg::RST_PULSE_HIGH;
            r_cfg.settle_us     <= clnb_pkg::RST_SETTLE;
            r_cfg.post_byte_us  <= clnb_pkg::RST_POST_BYTE;
            r_cfg.power_up_us   <= clnb_pkg::RST_POWER_UP;
            r_cfg.first_wake_us <= clnb_pkg::RST_FIRST_WAKE;
            r_cfg.wake_us       <= clnb_pkg::RST_WAKE;
        end else if (wr_en) begin
            case (reg_idx)
                clnb_pkg::REG_PULSE_HIGH: r_cfg.pulse_high_us <= pwdata[7:0];
                clnb_pkg::REG_SETTLE:     r_cfg.settle_us     <= pwdata[15:0];
                clnb_pkg::REG_POST_BYTE:  r_cfg.post_byte_us  <= pwdata[15:0];
                clnb_pkg::REG_POWER_UP:   r_cfg.power_up_us   <= pwdata[15:0];
                clnb_pkg::REG_FIRST_WAKE: r_cfg.first_wake_us <= pwdata[15:0];
                clnb_pkg::REG_WAKE:       r_cfg.wake_us       <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            clnb_pkg::REG_PULSE_HIGH: prdata = {24'd0, r_cfg.pulse_high_us};
            clnb_pkg::REG_SETTLE:     prdata = {16'd0, r_cfg.settle_us};
            clnb_pkg::REG_POST_BYTE:  prdata = {16'd0, r_cfg.post_byte_us};
            clnb_pkg::REG_POWER_UP:   prdata = {16'd0, r_cfg.power_up_us};
            clnb_pkg::REG_FIRST_WAKE: prdata = {16'd0, r_cfg.first_wake_us};
            clnb_pkg::REG_WAKE:       prdata = {16'd0, r_cfg.wake_us};
            default:                  prdata = 32'd0;
        endcase
    end

endmodule

### rtl/core/clnb_seq_core.sv
// Sequencer state and single-pass next-state logic for one request or tick.
module clnb_seq_core #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic [clnb_pkg::OP_W-1:0]  i_operation,
    input  logic [7:0]                 i_byte_value,
    input  logic                       i_line_index,
    input  logic [5:0]                 i_column,
    input  clnb_pkg::t_cfg             i_cfg,
    output clnb_pkg::t_result          o_result
);

    localparam logic [32:0]            DELAY_MAX33 = (33'd1 << DELAY_WIDTH) - 33'd1;
    localparam logic [DELAY_WIDTH-1:0] DELAY_ONE   = DELAY_WIDTH'(1);

    typedef struct packed {
        logic [clnb_pkg::STEP_W-1:0]  step;
        logic [clnb_pkg::PHASE_W-1:0] phase;
        logic [DELAY_WIDTH-1:0]       delay;
        logic [7:0]                   pending;
        logic                         low;
        logic                         extra;
        logic                         rs;
        logic                         en;
        logic [3:0]                   nib;
    } t_seq;

    t_seq       r_seq;
    t_seq       n_seq;
    logic       accepted;
    logic [6:0] cursor_addr;

    function automatic logic [DELAY_WIDTH-1:0] sat_wait(input logic [15:0] w);
        logic [DELAY_WIDTH-1:0] d;
        if ({17'd0, w} > DELAY_MAX33) begin
            d = DELAY_MAX33[DELAY_WIDTH-1:0];
        end else begin
            d = DELAY_WIDTH'(w);
        end
        return d;
    endfunction

    function automatic t_seq enter_ph(input t_seq s, input logic [clnb_pkg::PHASE_W-1:0] ph,
                                      input logic [DELAY_WIDTH-1:0] w);
        t_seq t;
        t       = s;
        t.phase = ph;
        t.delay = w;
        return t;
    endfunction

    function automatic t_seq start_pulse(input t_seq s, input logic [3:0] nib,
                                         input clnb_pkg::t_cfg cfg);
        t_seq t;
        t     = s;
        t.nib = nib;
        t.en  = 1'b1;
        t     = enter_ph(t, clnb_pkg::PH_EN, (cfg.pulse_high_us == 8'd0) ?
                         DELAY_ONE : DELAY_WIDTH'(cfg.pulse_high_us));
        return t;
    endfunction

    function automatic t_seq start_byte(input t_seq s, input clnb_pkg::t_cfg cfg);
        t_seq t;
        t     = s;
        t.low = 1'b0;
        t     = start_pulse(t, t.pending[7:4], cfg);
        return t;
    endfunction

    function automatic t_seq begin_item(input t_seq s, input logic [clnb_pkg::STEP_W-1:0] st,
                                        input clnb_pkg::t_cfg cfg);
        t_seq t;
        t      = s;
        t.step = st;
        if (st == clnb_pkg::STEP_POWER) begin
            t = enter_ph(t, clnb_pkg::PH_POWER, sat_wait(cfg.power_up_us));
        end else if (st inside {[clnb_pkg::STEP_WAKE_FIRST:clnb_pkg::STEP_BUS4]}) begin
            t.rs = 1'b0;
            t    = start_pulse(t, (st == clnb_pkg::STEP_BUS4) ? clnb_pkg::BUS4_NIBBLE :
                               clnb_pkg::WAKE_NIBBLE, cfg);
        end else if (st inside {[clnb_pkg::STEP_CMD_FIRST:clnb_pkg::STEP_CMD_LAST]}) begin
            t.rs      = 1'b0;
            t.pending = clnb_pkg::init_cmd(2'(st - clnb_pkg::STEP_CMD_FIRST));
            t         = start_byte(t, cfg);
        end else begin
            t = start_byte(t, cfg);
        end
        return t;
    endfunction

    function automatic t_seq advance(input t_seq s, input clnb_pkg::t_cfg cfg);
        t_seq        t;
        logic [15:0] w;
        t = s;
        w = 16'd0;
        case (s.phase)
            clnb_pkg::PH_POWER: begin
                t = begin_item(t, clnb_pkg::STEP_WAKE_FIRST, cfg);
            end
            clnb_pkg::PH_EN: begin
                t.en = 1'b0;
                t    = enter_ph(t, clnb_pkg::PH_SETTLE, sat_wait(cfg.settle_us));
            end
            clnb_pkg::PH_SETTLE: begin
                if (s.step inside {[clnb_pkg::STEP_WAKE_FIRST:clnb_pkg::STEP_BUS4]}) begin
                    if (s.step == clnb_pkg::STEP_WAKE_FIRST) begin
                        w = cfg.first_wake_us;
                    end else if (s.step != clnb_pkg::STEP_BUS4) begin
                        w = cfg.wake_us;
                    end
                    t = enter_ph(t, clnb_pkg::PH_GAP, sat_wait(w));
                end else if (!s.low) begin
                    t.low = 1'b1;
                    t     = start_pulse(t, s.pending[3:0], cfg);
                end else begin
                    t = enter_ph(t, clnb_pkg::PH_GAP, sat_wait(cfg.post_byte_us));
                end
            end
            clnb_pkg::PH_GAP: begin
                if (s.step inside {[clnb_pkg::STEP_POWER:clnb_pkg::STEP_CMD_LAST - 5'd1]}) begin
                    t = begin_item(t, s.step + 5'd1, cfg);
                end else if (s.extra) begin
                    t.extra = 1'b0;
                    t       = enter_ph(t, clnb_pkg::PH_EXTRA, sat_wait(cfg.post_byte_us));
                end else begin
                    t.step = clnb_pkg::STEP_IDLE;
                    t      = enter_ph(t, clnb_pkg::PH_IDLE, '0);
                end
            end
            default: begin
                t.step = clnb_pkg::STEP_IDLE;
                t      = enter_ph(t, clnb_pkg::PH_IDLE, '0);
            end
        endcase
        return t;
    endfunction

    assign cursor_addr = (i_line_index ? clnb_pkg::LINE1_BASE : clnb_pkg::LINE0_BASE)
                       + {1'b0, i_column};

    always_comb begin
        n_seq    = r_seq;
        accepted = 1'b0;
        if (i_operation == clnb_pkg::OP_TICK) begin
            if (r_seq.phase != clnb_pkg::PH_IDLE && r_seq.delay != '0) begin
                n_seq.delay = r_seq.delay - DELAY_ONE;
            end
        end else if (i_operation inside {[clnb_pkg::OP_CMD:clnb_pkg::OP_CLEAR]} &&
                     r_seq.phase == clnb_pkg::PH_IDLE) begin
            accepted    = 1'b1;
            n_seq.low   = 1'b0;
            n_seq.extra = 1'b0;
            case (i_operation)
                clnb_pkg::OP_INIT: begin
                    n_seq.extra = 1'b1;
                    n_seq       = begin_item(n_seq, clnb_pkg::STEP_POWER, i_cfg);
                end
                clnb_pkg::OP_DATA: begin
                    n_seq.rs      = 1'b1;
                    n_seq.pending = i_byte_value;
                    n_seq         = begin_item(n_seq, clnb_pkg::STEP_SINGLE, i_cfg);
                end
                clnb_pkg::OP_CURSOR: begin
                    n_seq.rs      = 1'b0;
                    n_seq.pending = clnb_pkg::CURSOR_CMD | {1'b0, cursor_addr};
                    n_seq         = begin_item(n_seq, clnb_pkg::STEP_SINGLE, i_cfg);
                end
                clnb_pkg::OP_CLEAR: begin
                    n_seq.rs      = 1'b0;
                    n_seq.pending = clnb_pkg::CLEAR_CMD;
                    n_seq.extra   = 1'b1;
                    n_seq         = begin_item(n_seq, clnb_pkg::STEP_SINGLE, i_cfg);
                end
                default: begin
                    n_seq.rs      = 1'b0;
                    n_seq.pending = i_byte_value;
                    n_seq         = begin_item(n_seq, clnb_pkg::STEP_SINGLE, i_cfg);
                end
            endcase
        end
        // zero-length waits fall through in the same item
        for (int k = 0; k < clnb_pkg::ZERO_RUN_MAX; k++) begin
            if (n_seq.phase != clnb_pkg::PH_IDLE && n_seq.delay == '0) begin
                n_seq = advance(n_seq, i_cfg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (i_fire) begin
            r_seq <= n_seq;
        end
    end

    assign o_result.rs_level   = n_seq.rs;
    assign o_result.en_level   = n_seq.en;
    assign o_result.bus_nibble = n_seq.nib;
    assign o_result.busy_res   = (n_seq.phase != clnb_pkg::PH_IDLE);
    assign o_result.accepted   = accepted;

    a_idle_en_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq.phase == clnb_pkg::PH_IDLE) |-> !r_seq.en)
        else $error("enable high while idle");

    a_en_phase_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq.phase == clnb_pkg::PH_EN) |-> r_seq.en)
        else $error("enable low during pulse phase");

    a_no_zero_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq.phase != clnb_pkg::PH_IDLE) |-> (r_seq.delay != '0))
        else $error("zero wait left unresolved");

    a_step_matches_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_seq.step == clnb_pkg::STEP_IDLE) == (r_seq.phase == clnb_pkg::PH_IDLE)))
        else $error("step and phase disagree on idle");

endmodule

### rtl/core/char_lcd_nibble_bus_sequencer_unit.sv
// Top level of the character LCD 4-bit bus sequencer.
// Requests wait in the input register; results are registered once the output is free.
// Throughput: one request per cycle unless the output stalls; each item is one step-logic pass.
// The output register lets a new request enter while a result waits to be taken.
// Reset (i_rst_n low, synchronous): timing registers return to defaults,
// the sequencer state goes idle with RS, EN and D4-D7 low, and both stages empty (r_result is not reset).
module char_lcd_nibble_bus_sequencer_unit #(
    parameter int DELAY_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [clnb_pkg::OP_W-1:0]     i_operation,
    input  logic [7:0]                    i_byte_value,
    input  logic                          i_line_index,
    input  logic [5:0]                    i_column,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_rs_level,
    output logic                          o_en_level,
    output logic [3:0]                    o_bus_nibble,
    output logic                          o_busy_res,
    output logic                          o_accepted,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clnb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic                       r_in_valid;
    logic [clnb_pkg::OP_W-1:0]  r_operation;
    logic [7:0]                 r_byte_value;
    logic                       r_line_index;
    logic [5:0]                 r_column;
    logic                       r_out_valid;
    clnb_pkg::t_result          r_result;

    clnb_pkg::t_cfg             cfg;
    clnb_pkg::t_result          n_result;
    logic                       fire;
    logic                       in_take;

    assign fire       = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | fire;
    assign in_take    = i_in_valid & o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_operation  <= i_operation;
            r_byte_value <= i_byte_value;
            r_line_index <= i_line_index;
            r_column     <= i_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= n_result;
        end
    end

    clnb_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clnb_seq_core #(
        .DELAY_WIDTH (DELAY_WIDTH)
    ) u_seq_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_operation  (r_operation),
        .i_byte_value (r_byte_value),
        .i_line_index (r_line_index),
        .i_column     (r_column),
        .i_cfg        (cfg),
        .o_result     (n_result)
    );

    assign o_out_valid  = r_out_valid;
    assign o_rs_level   = r_result.rs_level;
    assign o_en_level   = r_result.en_level;
    assign o_bus_nibble = r_result.bus_nibble;
    assign o_busy_res   = r_result.busy_res;
    assign o_accepted   = r_result.accepted;

endmodule
